### rtl/gs3v_pkg.sv
// ----------------------------------------------------------------------------
// gs3v_pkg
// Shared types and constants for the 3D Gaussian voxel smoother.
// ----------------------------------------------------------------------------
package gs3v_pkg;

    localparam int DATA_W = 16;  // voxel and weight width
    localparam int CRD_W  = 5;   // coordinate width
    localparam int TAP_W  = 10;  // kernel index port width
    localparam int SZ_W   = 9;   // clamped extent, holds up to 256
    localparam int R_W    = 3;   // clamped reach, holds up to 4
    localparam int SIDE_W = 5;   // kernel side, up to 17
    localparam int TAPC_W = 15;  // kernel volume compare width, up to 17^3

    localparam logic [1:0] OP_WR_VOXEL  = 2'd0;
    localparam logic [1:0] OP_WR_KERNEL = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_REACH  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_BREAD,
        ST_BOUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

### rtl/gs3v_mac.sv
// ----------------------------------------------------------------------------
// gs3v_mac
// Shared multiply-accumulate unit: registered 16x16 product, then accumulate.
// ----------------------------------------------------------------------------
module gs3v_mac #(
    parameter int ACC_W = 45
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gs3v_pkg::t_mac_ctrl       i_ctrl,
    input  logic [15:0]               i_weight,
    input  logic [15:0]               i_voxel,
    output logic [ACC_W-1:0]          o_acc,
    output logic                      o_busy
);
    import gs3v_pkg::*;

    logic [2*DATA_W-1:0] r_prod;
    logic                r_pvalid;
    logic [ACC_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * i_voxel;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_pvalid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pvalid;

endmodule

### rtl/gaussian_smooth_3d_voxel.sv
// ----------------------------------------------------------------------------
// gaussian_smooth_3d_voxel
// Stored 3D volume with a cubic Gaussian kernel; answers smoothed voxels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present i_op, position, i_data_word and i_tap_index with
//   start high; the command is taken at a clock edge where busy is low.
//   Voxel and kernel writes complete at that edge and return nothing.
//   A query returns one beat on o_smoothed/o_interior/o_saturated, marked by
//   o_valid for one cycle.
//   Answers: a query outside the volume answers in the next cycle; a border
//   query passes through the BREAD and BOUT states; an interior query walks
//   side^3 taps (side = 4*reach+1), one per cycle through the single
//   multiply-accumulate unit, and answers after a drain. The rate is set by the
//   one read port of each memory feeding that unit.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write the extent and reach
//   registers; users must write only while the block is idle (unchecked).
//   Reset: sizes go to 32, reach to 1; memory contents are not cleared and
//   read as undefined until written.
//   The receiver cannot stall: each result beat is shown exactly once.
// ----------------------------------------------------------------------------
module gaussian_smooth_3d_voxel #(
    parameter int MAX_X     = 32,
    parameter int MAX_Y     = 32,
    parameter int MAX_Z     = 32,
    parameter int MAX_REACH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_pos_x,
    input  logic [4:0]  i_pos_y,
    input  logic [4:0]  i_pos_z,
    input  logic [15:0] i_data_word,
    input  logic [9:0]  i_tap_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_smoothed,
    output logic        o_interior,
    output logic        o_saturated
);
    import gs3v_pkg::*;

    localparam int VDEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int KSIDE  = 4 * MAX_REACH + 1;
    localparam int KDEPTH = KSIDE * KSIDE * KSIDE;
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int KAW    = $clog2(KDEPTH);
    localparam int ACC_W  = 2 * DATA_W + KAW;

    // configuration
    logic [5:0] r_size_x, r_size_y, r_size_z;
    logic [1:0] r_reach;

    // sequencer
    t_state r_state, n_state;
    logic   c_accept, c_query, c_inside, c_interior, c_tap_ok;
    logic   c_ld_query, c_issue, c_out_zero, c_out_filt, c_out_border;
    logic   c_last, c_empty;

    // derived configuration
    logic [SZ_W-1:0]   sx, sy, sz;
    logic [R_W-1:0]    rl;
    logic [SIDE_W-1:0] cen, side;
    logic [9:0]        side_sq;
    logic [TAPC_W-1:0] side3;

    // tap walk
    logic [SIDE_W-1:0] r_dx, r_dy, r_dz;
    logic [CRD_W-1:0]  r_bx, r_by, r_bz;
    logic [KAW-1:0]    r_kidx, r_kaddr;
    logic [VAW-1:0]    r_vaddr, n_vaddr;
    logic              r_s0, r_s1;

    // memories
    logic [DATA_W-1:0] mem_v [VDEPTH];
    logic [DATA_W-1:0] mem_k [KDEPTH];
    logic [DATA_W-1:0] r_vdat, r_kdat;

    // result
    t_mac_ctrl         mac_ctrl;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_busy;
    logic              acc_sat;
    logic              r_valid, r_interior, r_saturated;
    logic [DATA_W-1:0] r_smoothed;

    function automatic logic [VAW-1:0] vox_addr(input logic [CRD_W-1:0] x,
                                                input logic [CRD_W-1:0] y,
                                                input logic [CRD_W-1:0] z);
        logic [VAW-1:0] yz;
        yz = VAW'(y) + VAW'(MAX_Y) * VAW'(z);
        return VAW'(x) + VAW'(MAX_X) * yz;
    endfunction

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32;
            r_size_y <= 6'd32;
            r_size_z <= 6'd32;
            r_reach  <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_REACH:  r_reach  <= i_cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // clamp extents and reach to what the storage holds
    always_comb begin
        sx = (SZ_W'(r_size_x) > SZ_W'(MAX_X)) ? SZ_W'(MAX_X) : SZ_W'(r_size_x);
        sy = (SZ_W'(r_size_y) > SZ_W'(MAX_Y)) ? SZ_W'(MAX_Y) : SZ_W'(r_size_y);
        sz = (SZ_W'(r_size_z) > SZ_W'(MAX_Z)) ? SZ_W'(MAX_Z) : SZ_W'(r_size_z);
        rl = ({1'b0, r_reach} > R_W'(MAX_REACH)) ? R_W'(MAX_REACH)
                                                 : {1'b0, r_reach};
        cen     = SIDE_W'({rl, 1'b0});
        side    = {rl, 2'b01};
        side_sq = 10'(side) * 10'(side);
        side3   = TAPC_W'(side_sq) * TAPC_W'(side);
    end

    // ---------------- command decode ----------------
    always_comb begin
        c_accept = start && !busy;
        c_query  = c_accept && (i_op == OP_QUERY);
        c_inside = (SZ_W'(i_pos_x) < sx) && (SZ_W'(i_pos_y) < sy)
                   && (SZ_W'(i_pos_z) < sz);
        c_interior = (SZ_W'(i_pos_x) >= SZ_W'(cen))
                     && (SZ_W'(i_pos_x) + SZ_W'(cen) < sx)
                     && (SZ_W'(i_pos_y) >= SZ_W'(cen))
                     && (SZ_W'(i_pos_y) + SZ_W'(cen) < sy)
                     && (SZ_W'(i_pos_z) >= SZ_W'(cen))
                     && (SZ_W'(i_pos_z) + SZ_W'(cen) < sz);
        c_tap_ok = (TAPC_W'(i_tap_index) < side3)
                   && (TAPC_W'(i_tap_index) < TAPC_W'(KDEPTH));
        c_last   = (r_dy == side - 1'b1) && (r_dx == side - 1'b1)
                   && (r_dz == side - 1'b1);
        c_empty  = !r_s0 && !r_s1 && !mac_busy;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (c_query && c_inside) begin
                    n_state = c_interior ? ST_WALK : ST_BREAD;
                end
            end
            ST_WALK: begin
                if (c_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (c_empty) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BREAD: n_state = ST_BOUT;
            ST_BOUT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        busy         = 1'b1;
        c_ld_query   = 1'b0;
        c_issue      = 1'b0;
        c_out_zero   = 1'b0;
        c_out_filt   = 1'b0;
        c_out_border = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                c_ld_query = c_query && c_inside;
                c_out_zero = c_query && !c_inside;
            end
            ST_WALK:  c_issue      = 1'b1;
            ST_DRAIN: c_out_filt   = c_empty;
            ST_BREAD: ;
            ST_BOUT:  c_out_border = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s0    <= 1'b0;
            r_s1    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s0    <= c_issue;
            r_s1    <= r_s0;
            r_valid <= c_out_zero || c_out_filt || c_out_border;
        end
    end

    // ---------------- tap walk ----------------
    always_comb begin
        if (c_issue) begin
            n_vaddr = vox_addr(r_bx + r_dx[CRD_W-1:0], r_by + r_dy[CRD_W-1:0],
                               r_bz + r_dz[CRD_W-1:0]);
        end else if (c_ld_query) begin
            n_vaddr = vox_addr(i_pos_x, i_pos_y, i_pos_z);
        end else begin
            n_vaddr = r_vaddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vaddr <= n_vaddr;
        if (c_ld_query) begin
            r_bx   <= i_pos_x - cen[CRD_W-1:0];
            r_by   <= i_pos_y - cen[CRD_W-1:0];
            r_bz   <= i_pos_z - cen[CRD_W-1:0];
            r_dx   <= '0;
            r_dy   <= '0;
            r_dz   <= '0;
            r_kidx <= '0;
        end else if (c_issue) begin
            r_kaddr <= r_kidx;
            r_kidx  <= r_kidx + 1'b1;
            // advance y fastest, then x, then z
            if (r_dy == side - 1'b1) begin
                r_dy <= '0;
                if (r_dx == side - 1'b1) begin
                    r_dx <= '0;
                    r_dz <= r_dz + 1'b1;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end else begin
                r_dy <= r_dy + 1'b1;
            end
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (c_accept && (i_op == OP_WR_VOXEL) && c_inside) begin
            mem_v[vox_addr(i_pos_x, i_pos_y, i_pos_z)] <= i_data_word;
        end
        r_vdat <= mem_v[r_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_accept && (i_op == OP_WR_KERNEL) && c_tap_ok) begin
            mem_k[KAW'(i_tap_index)] <= i_data_word;
        end
        r_kdat <= mem_k[r_kaddr];
    end

    // ---------------- accumulate ----------------
    assign mac_ctrl.clear = c_ld_query;
    assign mac_ctrl.valid = r_s1;

    gs3v_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_weight (r_kdat),
        .i_voxel  (r_vdat),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    assign acc_sat = |mac_acc[ACC_W-1:2*DATA_W];

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (c_out_zero) begin
            r_smoothed  <= '0;
            r_interior  <= 1'b0;
            r_saturated <= 1'b0;
        end else if (c_out_filt) begin
            r_smoothed  <= acc_sat ? {DATA_W{1'b1}} : mac_acc[2*DATA_W-1:DATA_W];
            r_interior  <= 1'b1;
            r_saturated <= acc_sat;
        end else if (c_out_border) begin
            r_smoothed  <= r_vdat;
            r_interior  <= 1'b0;
            r_saturated <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_smoothed  = r_smoothed;
    assign o_interior  = r_interior;
    assign o_saturated = r_saturated;

endmodule

### rtl/gs3v_checker.sv
// ----------------------------------------------------------------------------
// gs3v_checker
// Port-level checks for the 3D Gaussian voxel smoother, bound to the top.
// ----------------------------------------------------------------------------
module gs3v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_op,
    input logic       o_valid,
    input logic       o_interior,
    input logic       o_saturated
);
    import gs3v_pkg::*;

    // writes never produce a result beat
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_WR_VOXEL || i_op == OP_WR_KERNEL))
        |=> !o_valid)
        else $error("result beat after a write command");

    // an accepted query either starts work or answers at once
    a_query_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_QUERY) |=> (busy || o_valid))
        else $error("query accepted but neither busy nor answered");

    // no beat appears from an idle cycle without a command
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_valid)
        else $error("result beat without a command");

    // a beat is only shown once the work is done
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    // passthrough results never flag clamping
    a_border_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_interior) |-> !o_saturated)
        else $error("saturation flagged on a passthrough result");

endmodule

bind gaussian_smooth_3d_voxel gs3v_checker u_gs3v_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_op        (i_op),
    .o_valid     (o_valid),
    .o_interior  (o_interior),
    .o_saturated (o_saturated)
);

### dv/gaussian_smooth_3d_voxel_test.sv
// ----------------------------------------------------------------------------
// gaussian_smooth_3d_voxel_test
// Self-checking bench for the 3D Gaussian voxel smoother. A queue of voxel
// writes, kernel writes and queries feeds a bursty command driver. Each
// accepted beat updates a local copy of the volume and kernel, and each query
// predicts its smoothed value, which the monitor compares field by field.
// Unwritten voxels and weights are filled before any query that reads them.
// ----------------------------------------------------------------------------
module gaussian_smooth_3d_voxel_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gs3v_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         VOL_DIM     = 32;
    localparam int         KER_DEPTH   = 729;
    localparam int         SETTLE_CYC  = 740;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         FILL_CAP    = 150;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  x;
        logic [4:0]  y;
        logic [4:0]  z;
        logic [15:0] data;
        logic [9:0]  tap;
    } t_voxel_cmd;

    typedef struct packed {
        logic [15:0] smoothed;
        logic        interior;
        logic        saturated;
    } t_voxel_res;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [1:0]  i_op        = '0;
    logic [4:0]  i_pos_x     = '0;
    logic [4:0]  i_pos_y     = '0;
    logic [4:0]  i_pos_z     = '0;
    logic [15:0] i_data_word = '0;
    logic [9:0]  i_tap_index = '0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [5:0]  i_cfg_data  = '0;
    logic        o_valid;
    logic [15:0] o_smoothed;
    logic        o_interior;
    logic        o_saturated;

    gaussian_smooth_3d_voxel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_data_word (i_data_word),
        .i_tap_index (i_tap_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_smoothed  (o_smoothed),
        .o_interior  (o_interior),
        .o_saturated (o_saturated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the block state
    logic [15:0] vox_mem [VOL_DIM*VOL_DIM*VOL_DIM];
    logic [15:0] wt_mem  [KER_DEPTH];
    logic [5:0]  reg_sx    = 6'd32;
    logic [5:0]  reg_sy    = 6'd32;
    logic [5:0]  reg_sz    = 6'd32;
    logic [1:0]  reg_reach = 2'd1;

    // entries already written by queued beats
    bit vox_ok [VOL_DIM*VOL_DIM*VOL_DIM];
    bit wt_ok  [KER_DEPTH];

    t_voxel_cmd cmd_q[$];
    t_voxel_res smooth_exp_q[$];
    t_voxel_cmd cur_cmd;
    t_voxel_res pred_res;
    t_voxel_res want;

    int cmd_total    = 0;
    int accepted_cnt = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int burst_left   = 8;
    int gap_left     = 0;

    function automatic int eff_size(logic [5:0] v);
        return (v > 6'd32) ? 32 : int'(v);
    endfunction

    function automatic int eff_reach();
        return (reg_reach > 2'd2) ? 2 : int'(reg_reach);
    endfunction

    function automatic int tap_count();
        int side;
        side = 4 * eff_reach() + 1;
        return side * side * side;
    endfunction

    function automatic int vaddr(int x, int y, int z);
        return x + VOL_DIM * (y + VOL_DIM * z);
    endfunction

    function automatic bit in_volume(int x, int y, int z);
        return x < eff_size(reg_sx) && y < eff_size(reg_sy) && z < eff_size(reg_sz);
    endfunction

    function automatic bit in_core(int x, int y, int z);
        int c;
        c = 2 * eff_reach();
        return x >= c && x + c < eff_size(reg_sx) && y >= c && y + c < eff_size(reg_sy) &&
               z >= c && z + c < eff_size(reg_sz);
    endfunction

    // apply one accepted beat; returns 1 when it yields a result
    function automatic bit smooth_predict(t_voxel_cmd cmd, output t_voxel_res res);
        int          side;
        int          c;
        int          k;
        logic [47:0] acc;
        side = 4 * eff_reach() + 1;
        c    = 2 * eff_reach();
        res  = '0;
        case (cmd.op)
            OP_WR_VOXEL: begin
                if (in_volume(cmd.x, cmd.y, cmd.z))
                    vox_mem[vaddr(cmd.x, cmd.y, cmd.z)] = cmd.data;
                return 1'b0;
            end
            OP_WR_KERNEL: begin
                if (cmd.tap < tap_count())
                    wt_mem[cmd.tap] = cmd.data;
                return 1'b0;
            end
            OP_QUERY: begin
                if (!in_volume(cmd.x, cmd.y, cmd.z))
                    return 1'b1;
                if (in_core(cmd.x, cmd.y, cmd.z)) begin
                    acc = '0;
                    for (int dz = 0; dz < side; dz++)
                        for (int dx = 0; dx < side; dx++)
                            for (int dy = 0; dy < side; dy++) begin
                                k   = dz * side * side + dx * side + dy;
                                acc = acc + wt_mem[k] *
                                      vox_mem[vaddr(cmd.x + dx - c, cmd.y + dy - c,
                                                    cmd.z + dz - c)];
                            end
                    acc = acc >> 16;
                    if (acc > 48'd65535) begin
                        res.smoothed  = 16'hFFFF;
                        res.saturated = 1'b1;
                    end else begin
                        res.smoothed = acc[15:0];
                    end
                    res.interior = 1'b1;
                end else begin
                    res.smoothed = vox_mem[vaddr(cmd.x, cmd.y, cmd.z)];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] rand_voxel();
        return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 255))
                                           : 16'($urandom_range(0, 65535));
    endfunction

    // weights around a unit sum, so sums land on both sides of full scale
    function automatic logic [15:0] rand_weight();
        int cap;
        cap = 131072 / tap_count() + 1;
        if (cap > 65535)
            cap = 65535;
        return 16'($urandom_range(0, cap));
    endfunction

    // entries a query would read that no beat has written yet
    function automatic int fill_cost(int x, int y, int z);
        int side;
        int c;
        int n;
        side = 4 * eff_reach() + 1;
        c    = 2 * eff_reach();
        n    = 0;
        if (!in_volume(x, y, z))
            return 0;
        if (!in_core(x, y, z))
            return vox_ok[vaddr(x, y, z)] ? 0 : 1;
        for (int k = 0; k < tap_count(); k++)
            if (!wt_ok[k])
                n++;
        for (int dz = 0; dz < side; dz++)
            for (int dx = 0; dx < side; dx++)
                for (int dy = 0; dy < side; dy++)
                    if (!vox_ok[vaddr(x + dx - c, y + dy - c, z + dz - c)])
                        n++;
        return n;
    endfunction

    task automatic push_cmd(logic [1:0] op, int x, int y, int z, logic [15:0] data, int tap);
        t_voxel_cmd cmd;
        cmd.op   = op;
        cmd.x    = 5'(x);
        cmd.y    = 5'(y);
        cmd.z    = 5'(z);
        cmd.data = data;
        cmd.tap  = 10'(tap);
        if (op == OP_WR_VOXEL && in_volume(x, y, z))
            vox_ok[vaddr(x, y, z)] = 1'b1;
        if (op == OP_WR_KERNEL && tap < tap_count())
            wt_ok[tap] = 1'b1;
        cmd_q.push_back(cmd);
        cmd_total++;
    endtask

    // write whatever the query would read, then issue it
    task automatic add_query(int x, int y, int z);
        int side;
        int c;
        int vx;
        int vy;
        int vz;
        side = 4 * eff_reach() + 1;
        c    = 2 * eff_reach();
        if (in_volume(x, y, z)) begin
            if (in_core(x, y, z)) begin
                for (int k = 0; k < tap_count(); k++)
                    if (!wt_ok[k])
                        push_cmd(OP_WR_KERNEL, $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 31), rand_weight(), k);
                for (int dz = 0; dz < side; dz++)
                    for (int dx = 0; dx < side; dx++)
                        for (int dy = 0; dy < side; dy++) begin
                            vx = x + dx - c;
                            vy = y + dy - c;
                            vz = z + dz - c;
                            if (!vox_ok[vaddr(vx, vy, vz)])
                                push_cmd(OP_WR_VOXEL, vx, vy, vz, rand_voxel(),
                                         $urandom_range(0, 1023));
                        end
            end else if (!vox_ok[vaddr(x, y, z)]) begin
                push_cmd(OP_WR_VOXEL, x, y, z, rand_voxel(), $urandom_range(0, 1023));
            end
        end
        push_cmd(OP_QUERY, x, y, z, 16'($urandom_range(0, 65535)), $urandom_range(0, 1023));
    endtask

    task automatic pick_pos(int win, output int x, output int y, output int z);
        if ($urandom_range(0, 99) < 85) begin
            x = $urandom_range(0, win - 1);
            y = $urandom_range(0, win - 1);
            z = $urandom_range(0, win - 1);
        end else begin
            x = $urandom_range(0, 31);
            y = $urandom_range(0, 31);
            z = $urandom_range(0, 31);
        end
    endtask

    // keep far-off interior queries from pulling in a whole new neighborhood
    task automatic random_query(int win);
        int x;
        int y;
        int z;
        pick_pos(win, x, y, z);
        if (fill_cost(x, y, z) > FILL_CAP) begin
            x = $urandom_range(0, win - 1);
            y = $urandom_range(0, win - 1);
            z = $urandom_range(0, win - 1);
        end
        add_query(x, y, z);
    endtask

    task automatic run_random(int n, int win);
        int          sel;
        int          x;
        int          y;
        int          z;
        int          tap;
        logic [1:0]  op;
        logic [15:0] data;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 36) begin
                random_query(win);
            end else if (sel < 64) begin
                pick_pos(win, x, y, z);
                push_cmd(OP_WR_VOXEL, x, y, z, rand_voxel(), $urandom_range(0, 1023));
            end else if (sel < 80) begin
                tap  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, tap_count() - 1)
                                                    : $urandom_range(0, 1023);
                data = ($urandom_range(0, 9) < 7) ? rand_weight()
                                                  : 16'($urandom_range(0, 65535));
                push_cmd(OP_WR_KERNEL, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), data, tap);
            end else if (sel < 84) begin
                push_cmd(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), 16'($urandom_range(0, 65535)),
                         $urandom_range(0, 1023));
            end else begin
                // noise: any op, any field
                op = 2'($urandom_range(0, 3));
                if (op == OP_QUERY) begin
                    random_query(win);
                end else begin
                    push_cmd(op, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 31), 16'($urandom_range(0, 65535)),
                             $urandom_range(0, 1023));
                end
            end
        end
    endtask

    // wait until every queued beat is taken and answered, then let the block settle
    task automatic drain();
        while (accepted_cnt != cmd_total || smooth_exp_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SIZE_X: reg_sx = val;
            CFG_SIZE_Y: reg_sy = val;
            CFG_SIZE_Z: reg_sz = val;
            default:    reg_reach = val[1:0];
        endcase
    endtask

    task automatic set_config(int sx, int sy, int sz, int reach);
        drain();
        write_reg(CFG_SIZE_X, 6'(sx));
        write_reg(CFG_SIZE_Y, 6'(sy));
        write_reg(CFG_SIZE_Z, 6'(sz));
        write_reg(CFG_REACH, 6'(reach));
    endtask

    // command driver: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                accepted_cnt++;
                if (smooth_predict(cur_cmd, pred_res))
                    smooth_exp_q.push_back(pred_res);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_op        <= cur_cmd.op;
                    i_pos_x     <= cur_cmd.x;
                    i_pos_y     <= cur_cmd.y;
                    i_pos_z     <= cur_cmd.z;
                    i_data_word <= cur_cmd.data;
                    i_tap_index <= cur_cmd.tap;
                    start       <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(20, 40);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (smooth_exp_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected beat: expected none, actual smoothed %h",
                         $time, o_smoothed);
            end else begin
                want = smooth_exp_q.pop_front();
                if (o_smoothed !== want.smoothed) begin
                    err_cnt++;
                    $display("%0t: smoothed mismatch: expected %h actual %h",
                             $time, want.smoothed, o_smoothed);
                end
                if (o_interior !== want.interior) begin
                    err_cnt++;
                    $display("%0t: interior mismatch: expected %b actual %b",
                             $time, want.interior, o_interior);
                end
                if (o_saturated !== want.saturated) begin
                    err_cnt++;
                    $display("%0t: saturated mismatch: expected %b actual %b",
                             $time, want.saturated, o_saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, smooth_exp_q.size());
            $display("[gaussian_smooth_3d_voxel] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration
        run_random(110, 8);

        // single-tap kernel, x of two, y beyond the maximum, one slice
        set_config(2, 63, 1, 0);
        push_cmd(OP_UNUSED, 31, 31, 31, 16'hFFFF, 1023);
        push_cmd(OP_WR_KERNEL, 0, 0, 0, 16'hFFFF, 0);
        push_cmd(OP_WR_KERNEL, 0, 0, 0, 16'h1234, 1);
        push_cmd(OP_WR_KERNEL, 31, 31, 31, 16'h0000, 1023);
        push_cmd(OP_WR_VOXEL, 0, 0, 0, 16'hFFFF, 0);
        push_cmd(OP_WR_VOXEL, 1, 31, 0, 16'h0001, 1023);
        push_cmd(OP_WR_VOXEL, 2, 5, 0, 16'h7777, 0);
        push_cmd(OP_WR_VOXEL, 0, 5, 1, 16'h5555, 0);
        add_query(0, 0, 0);
        add_query(1, 31, 0);
        add_query(2, 0, 0);
        add_query(31, 31, 31);
        push_cmd(OP_WR_KERNEL, 0, 0, 0, 16'h8000, 0);
        add_query(0, 0, 0);

        // reach beyond the maximum: border passthrough
        set_config(32, 32, 32, 3);
        push_cmd(OP_WR_VOXEL, 31, 31, 31, 16'hABCD, 0);
        add_query(31, 31, 31);
        push_cmd(OP_WR_VOXEL, 3, 16, 20, 16'h0000, 512);
        add_query(3, 16, 20);
        add_query(0, 0, 0);

        // empty volume: everything lies outside
        set_config(0, 32, 32, 1);
        push_cmd(OP_WR_VOXEL, 0, 0, 0, 16'h0001, 0);
        add_query(0, 0, 0);

        set_config(6, 6, 6, 1);
        run_random(170, 6);
        set_config(9, 10, 9, 2);
        run_random(170, 10);
        set_config(3, 4, 5, 0);
        run_random(80, 6);
        set_config(63, 40, 33, 3);
        run_random(120, 10);
        set_config(1, 32, 5, 1);
        run_random(60, 8);
        set_config(12, 12, 12, 2);
        run_random(120, 12);

        drain();
        if (err_cnt == 0)
            $display("[gaussian_smooth_3d_voxel] OK");
        else
            $display("[gaussian_smooth_3d_voxel] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/gs3v_pkg.sv
rtl/gs3v_mac.sv
rtl/gaussian_smooth_3d_voxel.sv
rtl/gs3v_checker.sv
dv/gaussian_smooth_3d_voxel_test.sv
